FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on nothing; include by bare file name inside a module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/szz_pkg.sv
// Package for the mirror-pair zz correlation square unit.
// Holds types, constants and the saturation helper. No dependencies.
package szz_pkg;
    localparam int MAX_SPINS_DEF      = 16;
    localparam int PROB_FRAC_BITS_DEF = 32;
    localparam int PROB_W             = 32;
    localparam int SPIN_W             = 5;
    localparam int PAIR_W             = 3;
    localparam int ACC_W              = 34;
    localparam int TOT_W              = 49;
    localparam logic [SPIN_W-1:0] SPIN_RESET = 5'd8;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_ACC,
        t_ST_FIN_MUL1,
        t_ST_FIN_MUL2,
        t_ST_FIN_WB,
        t_ST_OUT_RD,
        t_ST_OUT
    } t_state;

    // saturates a 35-bit signed sum to a 34-bit signed value
    function automatic logic [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1])
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction
endpackage

FILE: design/spin_zz_correlation_square_unit.sv
// Top level of the mirror-pair zz correlation square unit.
// Depends on szz_pkg and assert_macros.svh.
//
// channel  dir  handshake            fields
// in       in   i_valid / o_ready    i_probability, i_end_of_state, i_end_of_set
// out      out  o_valid / i_ready    o_pair_index, o_corr_square, o_last_result
// cfg      in   i_cfg_we             i_cfg_data (spin_count)
//
// Each item makes P = spin_count/2 read-modify-write passes over the sum memory,
// one pair per cycle through its single read and write port. End of state passes
// each pair through registered steps: a 34x34 product, a 36-bit square, writeback.
// End of set then emits one beat per pair, read in t_ST_OUT_RD, held until taken.
// Reset is synchronous and clears control; the memories are cleared by a pass over
// all MAX_SPINS/2 entries after reset, during which o_ready is low.
// A stalled output beat holds the sequencer; nothing else is accepted meanwhile.
module spin_zz_correlation_square_unit #(
    parameter int MAX_SPINS      = szz_pkg::MAX_SPINS_DEF,
    parameter int PROB_FRAC_BITS = szz_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [szz_pkg::PROB_W-1:0]   i_probability,
    input  logic                         i_end_of_state,
    input  logic                         i_end_of_set,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [szz_pkg::PAIR_W-1:0]   o_pair_index,
    output logic [szz_pkg::PROB_W-1:0]   o_corr_square,
    output logic                         o_last_result,
    input  logic                         i_cfg_we,
    input  logic [szz_pkg::SPIN_W-1:0]   i_cfg_data
);
    import szz_pkg::*;
`include "assert_macros.svh"

    localparam int DEPTH = MAX_SPINS / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = MAX_SPINS;
    localparam int KB    = $clog2(KW);
    localparam int CW    = ACC_W + 2;
    localparam int MW    = 2 * CW;

    // sum memory: {left, right, joint}; total memory separate
    logic [3*ACC_W-1:0] r_sum_mem [DEPTH];
    logic [TOT_W-1:0]   r_tot_mem [DEPTH];
    logic [3*ACC_W-1:0] r_sum_rd;
    logic [TOT_W-1:0]   r_tot_rd;
    // flags totals beyond the active pairs at end of set; a flagged total reads as zero
    logic [DEPTH-1:0]   r_tot_stale;

    t_state r_state, n_state;
    logic [SPIN_W-1:0] r_spin;
    logic [KW-1:0]     r_k;
    logic [AW-1:0]     r_idx;
    logic              r_clr;
    logic [AW-1:0]     r_clr_idx;
    logic [PROB_W-1:0] r_p;
    logic              r_eos, r_eset;
    logic [SPIN_W-1:0] r_s;
    logic [MW-1:0]     r_mul;
    logic              r_neg;
    logic [ACC_W-1:0]  r_joint;
    logic [PROB_W-1:0] r_out_val;
    logic [PAIR_W-1:0] r_out_idx;
    logic              r_out_last;
    logic              r_ovalid;

    // effective spin count and pairs
    logic [SPIN_W-1:0] s_eff;
    always_comb begin
        if (r_spin < SPIN_W'(2))              s_eff = SPIN_W'(2);
        else if (r_spin > SPIN_W'(MAX_SPINS)) s_eff = SPIN_W'(MAX_SPINS);
        else                                  s_eff = r_spin;
    end
    logic [AW-1:0] last_pair;
    assign last_pair = AW'((r_s >> 1) - SPIN_W'(1));

    logic [DEPTH-1:0] hi_mask;
    always_comb begin
        for (int i = 0; i < DEPTH; i++) hi_mask[i] = (AW'(i) > last_pair);
    end

    // read address
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          idx_last;
    assign idx_last = (r_idx == last_pair);

    // accumulate on the read data of pair r_idx: read ahead, written back in this state
    logic [ACC_W-1:0] l_old, rr_old, j_old;
    assign l_old  = r_sum_rd[3*ACC_W-1:2*ACC_W];
    assign rr_old = r_sum_rd[2*ACC_W-1:ACC_W];
    assign j_old  = r_sum_rd[ACC_W-1:0];

    logic l_up, r_up;
    logic [KW-1:0] lpos;
    always_comb begin
        lpos = KW'(r_s) - KW'(1) - KW'(r_idx);
        r_up = r_k[KB'(r_idx)];
        l_up = r_k[lpos[KB-1:0]];
    end

    logic signed [ACC_W:0] pe;
    logic [ACC_W-1:0] l_new, r_new, j_new;
    assign pe = signed'({3'b000, r_p});
    always_comb begin
        l_new = sat_acc(signed'({l_old[ACC_W-1], l_old}) + (l_up ? pe : -pe));
        r_new = sat_acc(signed'({rr_old[ACC_W-1], rr_old}) + (r_up ? pe : -pe));
        j_new = sat_acc(signed'({j_old[ACC_W-1], j_old}) + ((l_up == r_up) ? pe : -pe));
    end

    // magnitudes (from the just-updated sums, held in r_sum_rd after writeback)
    function automatic logic [ACC_W-1:0] magf(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : v;
    endfunction

    // c = joint -/+ prod; a prod of 2^35 or more saturates c to its 37-bit signed limit
    logic [MW-1:0]      prod_sh;
    logic signed [CW:0] c_val;
    logic [CW-1:0]      c_mag;
    always_comb begin
        prod_sh = r_mul >> PROB_FRAC_BITS;
        if (|prod_sh[MW-1:CW-1]) c_val = r_neg ? signed'({1'b0, {CW{1'b1}}})
                                               : signed'({1'b1, {CW{1'b0}}});
        else if (r_neg) c_val = signed'({{3{r_joint[ACC_W-1]}}, r_joint})
                              + signed'({2'b00, prod_sh[CW-2:0]});
        else            c_val = signed'({{3{r_joint[ACC_W-1]}}, r_joint})
                              - signed'({2'b00, prod_sh[CW-2:0]});
        c_mag = c_val[CW] ? CW'(-c_val) : CW'(c_val);
    end

    logic [2*CW-1:0] sq_sh;
    logic [TOT_W:0]  tot_sum;
    logic [TOT_W-1:0] tot_new;
    assign sq_sh   = r_mul >> PROB_FRAC_BITS;
    assign tot_sum = {1'b0, r_tot_rd} + {1'b0, (|sq_sh[2*CW-1:TOT_W]) ?
                                         {TOT_W{1'b1}} : sq_sh[TOT_W-1:0]};
    assign tot_new = (|sq_sh[2*CW-1:TOT_W] || tot_sum[TOT_W]) ? {TOT_W{1'b1}}
                                                              : tot_sum[TOT_W-1:0];

    logic [TOT_W-1:0] shv;
    assign shv = r_tot_rd >> r_s;

    // state register and sequencing
    logic in_acc, out_fire;
    assign in_acc   = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;
    assign o_ready  = (r_state == t_ST_IDLE) && !r_clr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE:     if (in_acc) n_state = t_ST_ACC;
            t_ST_ACC:      if (idx_last) n_state = (r_eos || r_eset) ? t_ST_FIN_MUL1 : t_ST_IDLE;
            t_ST_FIN_MUL1: n_state = t_ST_FIN_MUL2;
            t_ST_FIN_MUL2: n_state = t_ST_FIN_WB;
            t_ST_FIN_WB:   n_state = idx_last ? (r_eset ? t_ST_OUT_RD : t_ST_IDLE)
                                              : t_ST_FIN_MUL1;
            t_ST_OUT_RD:   n_state = t_ST_OUT;
            t_ST_OUT:      if (out_fire) n_state = r_out_last ? t_ST_IDLE : t_ST_OUT_RD;
            default:       n_state = t_ST_IDLE;
        endcase
    end

    // memory read address: each entry is read in the cycle before its use
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        unique case (r_state)
            t_ST_IDLE:   begin rd_en = in_acc; rd_addr = '0; end
            t_ST_ACC:    begin rd_en = 1'b1; rd_addr = idx_last ? '0 : AW'(r_idx + 1'b1); end
            t_ST_FIN_WB: begin rd_en = 1'b1; rd_addr = idx_last ? '0 : AW'(r_idx + 1'b1); end
            t_ST_OUT:    begin rd_en = out_fire; rd_addr = AW'(r_idx + 1'b1); end
            default:     begin rd_en = 1'b0; rd_addr = r_idx; end
        endcase
    end

    // a read of the entry written in the same cycle takes the new value
    logic fwd_acc, fwd_wb;
    assign fwd_acc = (r_state == t_ST_ACC) && (rd_addr == r_idx);
    assign fwd_wb  = (r_state == t_ST_FIN_WB) && (rd_addr == r_idx);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_sum_rd <= fwd_acc ? {l_new, r_new, j_new} :
                        fwd_wb  ? '0 : r_sum_mem[rd_addr];
            r_tot_rd <= fwd_wb ? tot_new :
                        r_tot_stale[rd_addr] ? '0 : r_tot_mem[rd_addr];
        end
        if (r_clr) begin
            r_sum_mem[r_clr_idx] <= '0;
            r_tot_mem[r_clr_idx] <= '0;
        end else if (r_state == t_ST_ACC) begin
            r_sum_mem[r_idx] <= {l_new, r_new, j_new};
        end else if (r_state == t_ST_FIN_WB) begin
            r_sum_mem[r_idx] <= '0;
            r_tot_mem[r_idx] <= tot_new;
        end else if (r_state == t_ST_OUT && out_fire) begin
            r_tot_mem[r_idx] <= '0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p    <= i_probability;
            r_eos  <= i_end_of_state;
            r_eset <= i_end_of_set;
            r_s    <= s_eff;
        end
        if (r_state == t_ST_FIN_MUL1) begin
            r_mul   <= MW'(magf(l_old)) * MW'(magf(rr_old));
            r_neg   <= l_old[ACC_W-1] ^ rr_old[ACC_W-1];
            r_joint <= j_old;
        end else if (r_state == t_ST_FIN_MUL2) begin
            r_mul <= MW'(c_mag[CW-1:0]) * MW'(c_mag[CW-1:0]);
        end
        if (r_state == t_ST_OUT_RD) begin
            r_out_val  <= (|shv[TOT_W-1:PROB_W]) ? {PROB_W{1'b1}} : shv[PROB_W-1:0];
            r_out_idx  <= PAIR_W'(r_idx);
            r_out_last <= idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_ST_IDLE;
            r_spin      <= SPIN_RESET;
            r_k         <= '0;
            r_idx       <= '0;
            r_clr       <= 1'b1;
            r_clr_idx   <= '0;
            r_ovalid    <= 1'b0;
            r_tot_stale <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_spin <= i_cfg_data;
            if (r_clr) begin
                r_clr_idx <= AW'(r_clr_idx + 1'b1);
                if (r_clr_idx == AW'(DEPTH - 1)) r_clr <= 1'b0;
            end
            unique case (r_state)
                t_ST_IDLE: r_idx <= '0;
                t_ST_ACC: begin
                    if (idx_last) begin
                        r_idx <= '0;
                        if (r_eos || r_eset) r_k <= '0;
                        else r_k <= (r_k + 1'b1) & ((KW'(1) << r_s) - 1'b1);
                    end else begin
                        r_idx <= AW'(r_idx + 1'b1);
                    end
                end
                t_ST_FIN_WB: r_idx <= idx_last ? '0 : AW'(r_idx + 1'b1);
                t_ST_OUT: if (out_fire) r_idx <= AW'(r_idx + 1'b1);
                default: r_idx <= r_idx;
            endcase
            if (r_state == t_ST_FIN_WB)
                r_tot_stale[r_idx] <= 1'b0;
            else if (r_state == t_ST_OUT && out_fire && r_out_last)
                r_tot_stale <= r_tot_stale | hi_mask;
            if (r_state == t_ST_OUT_RD) r_ovalid <= 1'b1;
            else if (out_fire)          r_ovalid <= 1'b0;
        end
    end

    assign o_valid       = r_ovalid && (r_state == t_ST_OUT);
    assign o_pair_index  = r_out_idx;
    assign o_corr_square = r_out_val;
    assign o_last_result = r_out_last;

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != t_ST_IDLE, !o_ready)
    `ASSERT_IMPL(a_valid_in_out, i_clk, i_rst_n, o_valid, r_state == t_ST_OUT)
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, out_fire && o_last_result, r_state == t_ST_IDLE)
endmodule

FILE: tb/tb.sv
// Testbench for spin_zz_correlation_square_unit: directed table, then random sets.
// Depends on szz_pkg and the unit's RTL; predicts results in-line and checks each beat.
`timescale 1ns / 1ps

module tb;
    import szz_pkg::*;

    localparam int          PAIRS_MAX = MAX_SPINS_DEF / 2;
    localparam int          LIMIT     = 400000;
    localparam logic [63:0] ACC_HI    = 64'sd8589934591;
    localparam logic [63:0] ACC_LO    = -64'sd8589934592;
    localparam logic [63:0] TOT_HI    = 64'h1_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [PROB_W-1:0] corr;
        logic              last;
    } t_corr_beat;

    typedef struct {
        logic [PROB_W-1:0] prob;
        logic              eos;
        logic              eset;
        logic              chk;
        logic [PROB_W-1:0] corr0;
    } t_stim_row;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_ready;
    logic [PROB_W-1:0]   in_prob = '0;
    logic                in_eos = 0;
    logic                in_eset = 0;
    logic                out_valid;
    logic                out_ready = 0;
    logic [PAIR_W-1:0]   out_pair;
    logic [PROB_W-1:0]   out_corr;
    logic                out_last;
    logic                cfg_we = 0;
    logic [SPIN_W-1:0]   cfg_data = '0;

    // predictor state
    logic [SPIN_W-1:0]   spins_cfg;
    logic [15:0]         basis_idx;
    logic signed [63:0]  sum_l [PAIRS_MAX];
    logic signed [63:0]  sum_r [PAIRS_MAX];
    logic signed [63:0]  sum_j [PAIRS_MAX];
    logic [63:0]         tot   [PAIRS_MAX];
    t_corr_beat          expected_corr[$];

    int   errors = 0;
    int   beats_seen = 0;
    int   items_sent = 0;
    int   cycles = 0;
    int   in_idle_pct = 0;
    int   out_idle_pct = 0;
    bit   hold_out = 0;

    spin_zz_correlation_square_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_probability(in_prob), .i_end_of_state(in_eos), .i_end_of_set(in_eset),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_pair_index(out_pair), .o_corr_square(out_corr), .o_last_result(out_last),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL spin_zz_correlation_square_unit");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic logic signed [63:0] sat34(input logic signed [63:0] v);
        if (v > $signed(ACC_HI)) return $signed(ACC_HI);
        if (v < $signed(ACC_LO)) return $signed(ACC_LO);
        return v;
    endfunction

    // (a*b) >> 32 on magnitudes, saturating at 2^64-1
    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        if (p[127:96] != 0) return '1;
        return p[95:32];
    endfunction

    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int eff_spins();
        int s;
        s = spins_cfg;
        if (s < 2) s = 2;
        if (s > MAX_SPINS_DEF) s = MAX_SPINS_DEF;
        return s;
    endfunction

    task automatic predict_reset();
        spins_cfg = SPIN_RESET;
        basis_idx = 0;
        for (int i = 0; i < PAIRS_MAX; i++) begin
            sum_l[i] = 0; sum_r[i] = 0; sum_j[i] = 0; tot[i] = 0;
        end
    endtask

    task automatic predict_item(input logic [PROB_W-1:0] prob, input logic eos,
                                input logic eset);
        int s, pairs;
        logic [15:0] k, mask;
        logic signed [63:0] p, c;
        logic [63:0] pr, sq, v;
        logic lu, ru, neg;
        t_corr_beat b;
        s = eff_spins();
        pairs = s / 2;
        mask = 16'((32'd1 << s) - 1);
        k = basis_idx & mask;
        p = {32'd0, prob};
        for (int i = 0; i < pairs; i++) begin
            ru = k[i];
            lu = k[s-1-i];
            sum_l[i] = sat34(sum_l[i] + (lu ? p : -p));
            sum_r[i] = sat34(sum_r[i] + (ru ? p : -p));
            sum_j[i] = sat34(sum_j[i] + ((lu == ru) ? p : -p));
        end
        basis_idx = (k + 16'd1) & mask;
        if (eos || eset) begin
            for (int i = 0; i < pairs; i++) begin
                pr = mulq(magn(sum_l[i]), magn(sum_r[i]));
                neg = (sum_l[i] < 0) != (sum_r[i] < 0);
                c = neg ? sum_j[i] + $signed(pr) : sum_j[i] - $signed(pr);
                sq = mulq(magn(c), magn(c));
                tot[i] = (sq > TOT_HI - tot[i]) ? TOT_HI : tot[i] + sq;
                sum_l[i] = 0; sum_r[i] = 0; sum_j[i] = 0;
            end
            basis_idx = 0;
        end
        if (eset) begin
            for (int i = 0; i < PAIRS_MAX; i++) begin
                if (i < pairs) begin
                    v = tot[i] >> s;
                    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
                    b.pair = PAIR_W'(i);
                    b.corr = v[31:0];
                    b.last = (i + 1 == pairs);
                    expected_corr.push_back(b);
                end
                tot[i] = 0;
            end
        end
    endtask

    // result checker
    always @(posedge clk) begin
        t_corr_beat e;
        if (rst_n && out_valid && out_ready) begin
            beats_seen++;
            if (expected_corr.size() == 0) begin
                report($sformatf("unexpected beat pair %0d", out_pair));
            end else begin
                e = expected_corr.pop_front();
                if (out_pair !== e.pair)
                    report($sformatf("pair_index %0d exp %0d", out_pair, e.pair));
                if (out_corr !== e.corr)
                    report($sformatf("corr_square %h exp %h", out_corr, e.corr));
                if (out_last !== e.last)
                    report($sformatf("last_result %b exp %b", out_last, e.last));
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(negedge clk) begin
        if (hold_out)
            out_ready <= 0;
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // valid stays up after a beat only until the next falling edge decides
    task automatic send(input logic [PROB_W-1:0] prob, input logic eos, input logic eset);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_prob  <= prob;
        in_eos   <= eos;
        in_eset  <= eset;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(prob, eos, eset);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (expected_corr.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_spins(input logic [SPIN_W-1:0] v);
        drain();
        cfg_we   <= 1;
        cfg_data <= v;
        spins_cfg = v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [PROB_W-1:0] rand_prob();
        unique case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(255);
            2: return 32'hFFFF_FFFF - $urandom_range(255);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // one eigenstate set: small chains run full or past the wrap, large ones short
    task automatic send_set(input int nstates);
        int dim, len;
        dim = 1 << eff_spins();
        for (int st = 0; st < nstates; st++) begin
            if (dim <= 8)
                len = ($urandom_range(3) == 0) ? $urandom_range(1, dim + 2) : dim;
            else
                len = $urandom_range(1, 6);
            for (int n = 0; n < len; n++)
                send(rand_prob(), (n == len - 1) && ($urandom_range(7) != 0),
                     (st == nstates - 1) && (n == len - 1));
        end
    endtask

    t_stim_row table_rows[$];

    initial begin
        t_stim_row r;
        int spin_steps[] = '{2, 3, 4, 16, 0, 31, 5, 8, 2};
        predict_reset();
        repeat (4) @(negedge clk);
        rst_n <= 1;

        // directed: after reset, zero set gives zero; then extremes and odd cases
        r = '{32'd0, 1'b1, 1'b1, 1'b1, 32'd0};           table_rows.push_back(r);
        r = '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0};   table_rows.push_back(r);
        r = '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0};   table_rows.push_back(r);
        r = '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'd0};   table_rows.push_back(r);
        r = '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 32'd0};   table_rows.push_back(r);
        for (int n = 0; n < 20; n++) begin                // sum saturation
            r = '{32'hFFFF_FFFF, 1'b0, n == 19, 1'b0, 32'd0};
            table_rows.push_back(r);
        end
        in_idle_pct = 36; out_idle_pct = 61;
        foreach (table_rows[t]) begin
            if (table_rows[t].chk && table_rows[t].eset) begin
                send(table_rows[t].prob, table_rows[t].eos, table_rows[t].eset);
                if (expected_corr.size() != 0 && expected_corr[0].corr != table_rows[t].corr0)
                    report("predictor disagrees with table after reset");
            end else begin
                send(table_rows[t].prob, table_rows[t].eos, table_rows[t].eset);
            end
        end

        // pressure: hold the receiver while the sender keeps pushing
        drain();
        hold_out = 1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_out = 0;
            end
            begin
                send_set(2); send_set(1); send_set(1);
            end
        join

        foreach (spin_steps[m]) begin
            if (m == 3) begin in_idle_pct = 61; out_idle_pct = 36; end
            if (m == 6) begin in_idle_pct = 0;  out_idle_pct = 0;  end
            set_spins(SPIN_W'(spin_steps[m]));
            for (int q = 0; q < 3; q++) send_set($urandom_range(1, 2));
        end

        drain();
        $display("ran %0d items, %0d result beats over spin counts 0..31", items_sent,
                 beats_seen);
        if (errors == 0)
            $display("PASS spin_zz_correlation_square_unit");
        else
            $display("FAIL spin_zz_correlation_square_unit");
        $finish;
    end
endmodule
